### rtl/assert_macros.svh
// Assertion macros used by the top level of the pose accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PCA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCA_ASSERT(lbl, prop, msg)
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/pca_pkg.sv
// Package of the pose accumulator: constants, types and arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none
package pca_pkg;

	localparam int QUAT_FRAC_BITS = 30;
	localparam int DW = 32;
	localparam int MAG_W = 63;
	localparam int QUO_W = QUAT_FRAC_BITS + 1;
	localparam int NUM_W = QUAT_FRAC_BITS + 32;
	localparam int CNT_W = $clog2(QUO_W + 1);

	localparam logic signed [DW-1:0] Q_ONE = DW'(1) << QUAT_FRAC_BITS;
	localparam logic [MAG_W-1:0] M_HIGH = MAG_W'(1) << 30;
	localparam logic [MAG_W-1:0] M_LOW = MAG_W'(1) << 29;
	localparam logic [63:0] SQRT_TOP = 64'(1) << 62;

	// Quaternion component indexes
	localparam logic [1:0] QI_W = 2'd0;
	localparam logic [1:0] QI_X = 2'd1;
	localparam logic [1:0] QI_Y = 2'd2;
	localparam logic [1:0] QI_Z = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_COMMIT,
		ST_MAX,
		ST_SCALE,
		ST_ROOT,
		ST_DIV_GO,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_TRANS,
		PH_HAM,
		PH_SQ,
		PH_MAT
	} phase_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic neg;
		logic dbl;
		logic half;
	} mac_ctl_t;

	typedef struct packed {
		logic [1:0] ia;
		logic [1:0] ib;
		logic       neg;
		logic       dbl;
	} mat_term_t;

	typedef struct packed {
		logic              action;
		logic signed [31:0] in_quat_w;
		logic signed [31:0] in_quat_x;
		logic signed [31:0] in_quat_y;
		logic signed [31:0] in_quat_z;
		logic signed [31:0] in_trans_x;
		logic signed [31:0] in_trans_y;
		logic signed [31:0] in_trans_z;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] pose_quat_w;
		logic signed [31:0] pose_quat_x;
		logic signed [31:0] pose_quat_y;
		logic signed [31:0] pose_quat_z;
		logic signed [31:0] pose_trans_x;
		logic signed [31:0] pose_trans_y;
		logic signed [31:0] pose_trans_z;
	} res_t;

	// Sign of term k in Hamilton product component c
	function automatic logic ham_neg(input logic [1:0] c, input logic [1:0] k);
		logic n;
		case (c)
			QI_W:    n = (k != QI_W);
			QI_X:    n = (k == QI_Z);
			QI_Y:    n = (k == QI_X);
			QI_Z:    n = (k == QI_Y);
			default: n = 1'b0;
		endcase
		return n;
	endfunction

	// Operands of term k of matrix entry e (row major)
	function automatic mat_term_t mat_term(input logic [3:0] e, input logic [1:0] k);
		mat_term_t t;
		t.ia = k;
		t.ib = k;
		t.neg = 1'b0;
		t.dbl = 1'b1;
		case (e)
			4'd0: begin
				t.dbl = 1'b0;
				t.neg = (k == QI_Y) || (k == QI_Z);
			end
			4'd4: begin
				t.dbl = 1'b0;
				t.neg = (k == QI_X) || (k == QI_Z);
			end
			4'd8: begin
				t.dbl = 1'b0;
				t.neg = (k == QI_X) || (k == QI_Y);
			end
			4'd1: begin
				t.ia = k[0] ? QI_W : QI_X;
				t.ib = k[0] ? QI_Z : QI_Y;
				t.neg = k[0];
			end
			4'd2: begin
				t.ia = k[0] ? QI_W : QI_X;
				t.ib = k[0] ? QI_Y : QI_Z;
			end
			4'd3: begin
				t.ia = k[0] ? QI_W : QI_X;
				t.ib = k[0] ? QI_Z : QI_Y;
			end
			4'd5: begin
				t.ia = k[0] ? QI_W : QI_Y;
				t.ib = k[0] ? QI_X : QI_Z;
				t.neg = k[0];
			end
			4'd6: begin
				t.ia = k[0] ? QI_W : QI_X;
				t.ib = k[0] ? QI_Y : QI_Z;
				t.neg = k[0];
			end
			4'd7: begin
				t.ia = k[0] ? QI_W : QI_Y;
				t.ib = k[0] ? QI_X : QI_Z;
			end
			default: t.dbl = 1'b0;
		endcase
		return t;
	endfunction

	// Drop QUAT_FRAC_BITS fraction bits, rounding half away from zero
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v);
		logic [63:0] m;
		logic [63:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		r = (m + (64'(1) << (QUAT_FRAC_BITS - 1))) >> QUAT_FRAC_BITS;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (v < -35'sh0_8000_0000) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_unit(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(Q_ONE)) r = Q_ONE;
		else if (v < -64'(Q_ONE)) r = -Q_ONE;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] mag32(input logic signed [31:0] v);
		logic signed [32:0] w;
		w = v[31] ? -33'(v) : 33'(v);
		return MAG_W'(w);
	endfunction

	function automatic logic [MAG_W-1:0] mag64(input logic signed [63:0] v);
		logic signed [63:0] w;
		w = v[63] ? -v : v;
		return w[MAG_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/pca_cmd_if.sv
// Input channel of the pose accumulator: valid, ready and one command item.
`timescale 1ns / 1ps
`default_nettype none
interface pca_cmd_if;
	import pca_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/pca_res_if.sv
// Result channel of the pose accumulator: valid, ready and one pose item.
`timescale 1ns / 1ps
`default_nettype none
interface pca_res_if;
	import pca_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/pca_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, then scaled add.
`timescale 1ns / 1ps
`default_nettype none
module pca_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  pca_pkg::mac_ctl_t   ctl,
	input  logic signed [31:0]  a,
	input  logic signed [31:0]  b,
	output logic signed [63:0]  acc
);
	import pca_pkg::*;

	mac_ctl_t           ctl_s1;
	logic signed [63:0] p_s1;
	logic signed [63:0] p_adj;
	logic signed [63:0] term;
	logic signed [63:0] term_n;
	logic signed [63:0] acc_q;

	// Register the controls and the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	// Scale the product: halve toward zero, double or pass, then negate if asked
	always_comb begin
		p_adj = p_s1 + {63'd0, p_s1[63]};
		if (ctl_s1.half) term = p_adj >>> 1;
		else if (ctl_s1.dbl) term = p_s1 <<< 1;
		else term = p_s1;
		term_n = ctl_s1.neg ? -term : term;
	end

	// Accumulate, restarting on the first term of a group
	always_ff @(posedge clk) begin
		if (ctl_s1.en) begin
			acc_q <= (ctl_s1.clr ? 64'sd0 : acc_q) + term_n;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

### rtl/pca_isqrt.sv
// Integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pca_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);
	import pca_pkg::*;

	logic        busy_q;
	logic [63:0] bit_q;
	logic [63:0] x_q;
	logic [63:0] r_q;
	logic [63:0] trial;
	logic        fits;

	assign trial = r_q + bit_q;
	assign fits = (x_q >= trial);

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bit_q <= SQRT_TOP;
		end else if (busy_q) begin
			if (bit_q == '0) busy_q <= 1'b0;
			else bit_q <= bit_q >> 2;
		end
	end

	// Subtract the trial value where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			r_q <= '0;
		end else if (busy_q && (bit_q != '0)) begin
			if (fits) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign done = busy_q && (bit_q == '0);
	assign root = r_q[31:0];

endmodule
`default_nettype wire

### rtl/pca_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pca_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pca_pkg::NUM_W-1:0]   num,
	input  logic [31:0]                 den,
	output logic                        done,
	output logic [pca_pkg::QUO_W-1:0]   quo
);
	import pca_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      den_q;
	logic [31:0]      rem_q;
	logic [QUO_W-1:0] lo_q;
	logic [32:0]      t;
	logic             ge;

	assign t = {rem_q, lo_q[QUO_W-1]};
	assign ge = (t >= {1'b0, den_q});

	// Count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(QUO_W);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift in the next dividend bit and subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= 32'(num[NUM_W-1:QUO_W]);
			lo_q <= num[QUO_W-1:0];
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? 32'(t - {1'b0, den_q}) : t[31:0];
			lo_q <= {lo_q[QUO_W-2:0], ge};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign quo = lo_q;

endmodule
`default_nettype wire

### rtl/pose_composition_accumulator.sv
// Pose accumulator top level: sequencer, pose registers and shared units.
//
// Keeps a rigid pose (unit quaternion Q1.30, its rotation matrix and a Q16.16
// translation). A load item stores the normalized quaternion and the
// translation; a compose item adds the old matrix times the increment
// translation (saturating) and replaces the quaternion with the normalized
// Hamilton product of the stored and increment quaternions. Each item gives
// one result item with the new quaternion and translation. The block takes
// one item at a time and is not ready while it works. The quaternion is
// rescaled by up to 32 halvings or 29 doublings before it is normalized. The
// time is set by the single multiply-accumulate unit (one term a cycle), the
// bit-serial square root and the bit-serial divider (run for each of the four
// components). A zero quaternion skips the root and the divides. A finished
// result waits in an output register while the next item is taken; a result
// still waiting there when the next one is done stalls the block.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pose_composition_accumulator (
	input logic       clk,
	input logic       arst_n,
	pca_cmd_if.sink   cmd,
	pca_res_if.source res
);
	import pca_pkg::*;

	state_t             state_q;
	state_t             state_d;
	phase_t             ph_q;
	logic [3:0]         gc_q;
	logic [1:0]         tc_q;
	logic signed [31:0] quat_q [4];
	logic signed [31:0] quat2_q [4];
	logic signed [31:0] rot_q [9];
	logic signed [31:0] trans_q [3];
	logic signed [31:0] inq_q [4];
	logic signed [31:0] int_q [3];
	logic [MAG_W-1:0]   v_mag_q [4];
	logic [3:0]         v_neg_q;
	logic [MAG_W-1:0]   m_q;
	logic [31:0]        n_q;
	res_t               out_q;
	logic               out_valid_q;

	mac_ctl_t           mac_ctl;
	logic signed [31:0] mac_a;
	logic signed [31:0] mac_b;
	logic signed [63:0] acc;
	logic               root_start;
	logic               root_done;
	logic [31:0]        root;
	logic               div_start;
	logic               div_done;
	logic [QUO_W-1:0]   quo;
	logic [NUM_W-1:0]   div_num;

	mat_term_t          mt;
	logic [1:0]         vidx;
	logic [3:0]         rot_idx;
	logic [1:0]         qa_idx;
	logic [1:0]         in_idx;
	logic               diag_e;
	logic               last_term;
	logic               last_group;
	logic               m_hi;
	logic               m_lo;
	logic               out_free;
	logic [MAG_W-1:0]   vsel;
	logic signed [63:0] acc_rnd;
	logic signed [34:0] trans_sum;
	logic signed [31:0] quo_s;

	pca_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	pca_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.x      ($unsigned(acc)),
		.done   (root_done),
		.root   (root)
	);

	pca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (n_q),
		.done   (div_done),
		.quo    (quo)
	);

	// Decode term and group positions
	always_comb begin
		mt = mat_term(gc_q, tc_q);
		diag_e = gc_q inside {4'd0, 4'd4, 4'd8};
		case (ph_q)
			PH_TRANS: last_term = (tc_q == 2'd2);
			PH_MAT:   last_term = diag_e ? (tc_q == 2'd3) : (tc_q == 2'd1);
			default:  last_term = (tc_q == 2'd3);
		endcase
		case (ph_q)
			PH_TRANS: last_group = (gc_q == 4'd2);
			PH_HAM:   last_group = (gc_q == 4'd3);
			PH_SQ:    last_group = 1'b1;
			PH_MAT:   last_group = (gc_q == 4'd8);
			default:  last_group = 1'b1;
		endcase
	end

	// Shared datapath terms
	always_comb begin
		vidx = (state_q == ST_ISSUE) ? tc_q : gc_q[1:0];
		vsel = v_mag_q[vidx];
		rot_idx = gc_q * 4'd3 + {2'b00, tc_q};
		qa_idx = (ph_q == PH_MAT) ? mt.ia : tc_q;
		in_idx = gc_q[1:0] ^ tc_q;
		div_num = NUM_W'({vsel[30:0], {QUAT_FRAC_BITS{1'b0}}}) + NUM_W'(n_q >> 1);
		acc_rnd = round_shift(acc);
		trans_sum = 35'(trans_q[gc_q[1:0]]) + 35'(acc_rnd);
		quo_s = $signed(32'(quo));
		m_hi = (m_q > M_HIGH);
		m_lo = (m_q < M_LOW);
		out_free = !out_valid_q || res.ready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = cmd.data.action ? ST_MAX : ST_ISSUE;
			end
			ST_ISSUE: begin
				if (last_term) state_d = ST_WAIT;
			end
			ST_WAIT: state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (!last_group) state_d = ST_ISSUE;
				else begin
					case (ph_q)
						PH_TRANS: state_d = ST_ISSUE;
						PH_HAM:   state_d = ST_MAX;
						PH_SQ:    state_d = ST_ROOT;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_MAX: begin
				if (gc_q == 4'd3) state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if ((m_q == '0) || !(m_hi || m_lo)) state_d = ST_ISSUE;
			end
			ST_ROOT: begin
				if (root_done) state_d = ST_DIV_GO;
			end
			ST_DIV_GO: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) state_d = (gc_q == 4'd3) ? ST_ISSUE : ST_DIV_GO;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Drive the shared units
	always_comb begin
		mac_ctl = '0;
		mac_a = '0;
		mac_b = '0;
		if (state_q == ST_ISSUE) begin
			mac_ctl.en = 1'b1;
			mac_ctl.clr = (tc_q == 2'd0);
			case (ph_q)
				PH_TRANS: begin
					mac_a = rot_q[rot_idx];
					mac_b = int_q[tc_q];
				end
				PH_HAM: begin
					mac_a = quat_q[qa_idx];
					mac_b = inq_q[in_idx];
					mac_ctl.neg = ham_neg(gc_q[1:0], tc_q);
					mac_ctl.half = 1'b1;
				end
				PH_SQ: begin
					mac_a = $signed({1'b0, vsel[30:0]});
					mac_b = $signed({1'b0, vsel[30:0]});
				end
				default: begin
					mac_a = quat_q[qa_idx];
					mac_b = quat2_q[mt.ib];
					mac_ctl.neg = mt.neg;
					mac_ctl.dbl = mt.dbl;
				end
			endcase
		end
		root_start = (state_q == ST_COMMIT) && (ph_q == PH_SQ);
		div_start = (state_q == ST_DIV_GO);
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = out_valid_q;
	assign res.data = out_q;

	// Control and pose registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= PH_TRANS;
			gc_q <= '0;
			tc_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				quat_q[i] <= (i == 0) ? Q_ONE : '0;
				quat2_q[i] <= (i == 0) ? Q_ONE : '0;
			end
			for (int i = 0; i < 9; i++) begin
				rot_q[i] <= (i == 0 || i == 4 || i == 8) ? Q_ONE : '0;
			end
			for (int i = 0; i < 3; i++) begin
				trans_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			// Fill the result register when done, drop it once taken
			if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						gc_q <= '0;
						tc_q <= '0;
						ph_q <= PH_TRANS;
						if (cmd.data.action) begin
							trans_q[0] <= cmd.data.in_trans_x;
							trans_q[1] <= cmd.data.in_trans_y;
							trans_q[2] <= cmd.data.in_trans_z;
						end
					end
				end
				ST_ISSUE: begin
					tc_q <= last_term ? 2'd0 : tc_q + 2'd1;
				end
				ST_COMMIT: begin
					gc_q <= last_group ? 4'd0 : gc_q + 4'd1;
					if (ph_q == PH_TRANS) trans_q[gc_q[1:0]] <= sat32(trans_sum);
					if (ph_q == PH_MAT) rot_q[gc_q] <= clamp_unit(acc_rnd);
					if (last_group && (ph_q == PH_TRANS)) ph_q <= PH_HAM;
				end
				ST_MAX: begin
					gc_q <= (gc_q == 4'd3) ? 4'd0 : gc_q + 4'd1;
				end
				ST_SCALE: begin
					// Zero quaternion: store zeros and rebuild a zero matrix
					if (m_q == '0) begin
						ph_q <= PH_MAT;
						for (int i = 0; i < 4; i++) begin
							quat_q[i] <= '0;
							quat2_q[i] <= '0;
						end
					end else if (!(m_hi || m_lo)) begin
						ph_q <= PH_SQ;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						gc_q <= (gc_q == 4'd3) ? 4'd0 : gc_q + 4'd1;
						quat_q[gc_q[1:0]] <= v_neg_q[gc_q[1:0]] ? -quo_s : quo_s;
						quat2_q[gc_q[1:0]] <= v_neg_q[gc_q[1:0]] ? -quo_s : quo_s;
						if (gc_q == 4'd3) ph_q <= PH_MAT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working values and the result register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					inq_q[0] <= cmd.data.in_quat_w;
					inq_q[1] <= cmd.data.in_quat_x;
					inq_q[2] <= cmd.data.in_quat_y;
					inq_q[3] <= cmd.data.in_quat_z;
					int_q[0] <= cmd.data.in_trans_x;
					int_q[1] <= cmd.data.in_trans_y;
					int_q[2] <= cmd.data.in_trans_z;
					v_mag_q[0] <= mag32(cmd.data.in_quat_w);
					v_mag_q[1] <= mag32(cmd.data.in_quat_x);
					v_mag_q[2] <= mag32(cmd.data.in_quat_y);
					v_mag_q[3] <= mag32(cmd.data.in_quat_z);
					v_neg_q <= {cmd.data.in_quat_z[31], cmd.data.in_quat_y[31],
						cmd.data.in_quat_x[31], cmd.data.in_quat_w[31]};
					m_q <= '0;
				end
			end
			ST_COMMIT: begin
				if (ph_q == PH_HAM) begin
					v_mag_q[gc_q[1:0]] <= mag64(acc);
					v_neg_q[gc_q[1:0]] <= acc[63];
				end
			end
			ST_MAX: begin
				if (vsel > m_q) m_q <= vsel;
			end
			ST_SCALE: begin
				// Halve toward zero or double until the peak lies in range
				if (m_hi) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 4; i++) v_mag_q[i] <= v_mag_q[i] >> 1;
				end else if (m_lo && (m_q != '0)) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 4; i++) v_mag_q[i] <= v_mag_q[i] << 1;
				end
			end
			ST_ROOT: begin
				if (root_done) n_q <= root;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.pose_quat_w <= quat_q[0];
					out_q.pose_quat_x <= quat_q[1];
					out_q.pose_quat_y <= quat_q[2];
					out_q.pose_quat_z <= quat_q[3];
					out_q.pose_trans_x <= trans_q[0];
					out_q.pose_trans_y <= trans_q[1];
					out_q.pose_trans_z <= trans_q[2];
				end
			end
			default: begin
			end
		endcase
	end

	`PCA_ASSERT(a_root_in_wait, root_done |-> (state_q == ST_ROOT), "root ready outside its wait")
	`PCA_ASSERT(a_div_in_wait, div_done |-> (state_q == ST_DIV), "quotient ready outside its wait")
	`PCA_ASSERT(a_quat_unit, (state_q == ST_DONE) |-> ((quat_q[0] <= Q_ONE) && (quat_q[0] >= -Q_ONE)), "stored scalar part out of range")
	`PCA_ASSERT_NEXT(a_accept_busy, cmd.valid && cmd.ready, state_q != ST_IDLE, "item taken but sequencer idle")

endmodule
`default_nettype wire

### verif/pose_composition_accumulator_tb.sv
// Testbench of the pose accumulator: directed and random items checked against a pose predictor.
`timescale 1ns / 1ps
`default_nettype none
module pose_composition_accumulator_tb;
	import pca_pkg::*;

	logic clk;
	logic arst_n;
	pca_cmd_if cmd_ch();
	pca_res_if res_ch();

	pose_composition_accumulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// Predicted pose: quaternion, row-major matrix, translation
	longint pose_quat[4];
	longint pose_rot[9];
	longint pose_pos[3];
	res_t expected_poses[$];
	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold_cycles;

	// Clock, period 4 ns
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	// Drop QUAT_FRAC_BITS bits, rounding half away from zero
	function automatic longint drop_frac(input longint v);
		longint unsigned m;
		m = (magnitude(v) + (64'd1 << (QUAT_FRAC_BITS - 1))) >> QUAT_FRAC_BITS;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unit_clamp(input longint v);
		longint one;
		one = longint'(1) << QUAT_FRAC_BITS;
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	// Normalize a raw quaternion into the stored pose; zero stays zero
	function automatic void store_normalized(input longint raw[4]);
		longint unsigned m;
		longint unsigned s;
		longint unsigned n;
		longint unsigned q;
		longint v[4];
		m = 0;
		s = 0;
		v = raw;
		for (int i = 0; i < 4; i++) if (magnitude(v[i]) > m) m = magnitude(v[i]);
		if (m == 0) begin
			for (int i = 0; i < 4; i++) pose_quat[i] = 0;
			return;
		end
		while (m > (64'd1 << 30)) begin
			for (int i = 0; i < 4; i++) v[i] = v[i] / 2;
			m = m >> 1;
		end
		while (m < (64'd1 << 29)) begin
			for (int i = 0; i < 4; i++) v[i] = v[i] * 2;
			m = m << 1;
		end
		for (int i = 0; i < 4; i++) s = s + magnitude(v[i]) * magnitude(v[i]);
		n = int_sqrt(s);
		for (int i = 0; i < 4; i++) begin
			q = ((magnitude(v[i]) << QUAT_FRAC_BITS) + (n >> 1)) / n;
			pose_quat[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic void rebuild_rotation();
		longint w, x, y, z;
		longint e[9];
		w = pose_quat[0];
		x = pose_quat[1];
		y = pose_quat[2];
		z = pose_quat[3];
		e[0] = w * w + x * x - y * y - z * z;
		e[1] = 2 * (x * y - w * z);
		e[2] = 2 * (x * z + w * y);
		e[3] = 2 * (x * y + w * z);
		e[4] = w * w - x * x + y * y - z * z;
		e[5] = 2 * (y * z - w * x);
		e[6] = 2 * (x * z - w * y);
		e[7] = 2 * (y * z + w * x);
		e[8] = w * w - x * x - y * y + z * z;
		for (int i = 0; i < 9; i++) pose_rot[i] = unit_clamp(drop_frac(e[i]));
	endfunction

	function automatic void reset_pose();
		pose_quat[0] = longint'(1) << QUAT_FRAC_BITS;
		for (int i = 1; i < 4; i++) pose_quat[i] = 0;
		for (int i = 0; i < 9; i++) pose_rot[i] = (i % 4 == 0) ? pose_quat[0] : 0;
		for (int i = 0; i < 3; i++) pose_pos[i] = 0;
	endfunction

	// Apply one item to the predicted pose and return the expected result
	function automatic res_t compose_pose(input cmd_t c);
		longint q[4];
		longint t[3];
		longint v[4];
		longint a[4];
		longint acc;
		res_t r;
		q = '{c.in_quat_w, c.in_quat_x, c.in_quat_y, c.in_quat_z};
		t = '{c.in_trans_x, c.in_trans_y, c.in_trans_z};
		if (c.action) begin
			store_normalized(q);
			for (int i = 0; i < 3; i++) pose_pos[i] = t[i];
		end else begin
			a = pose_quat;
			for (int i = 0; i < 3; i++) begin
				acc = pose_rot[3*i] * t[0] + pose_rot[3*i+1] * t[1] + pose_rot[3*i+2] * t[2];
				acc = pose_pos[i] + drop_frac(acc);
				if (acc > 64'sd2147483647) acc = 64'sd2147483647;
				if (acc < -64'sd2147483648) acc = -64'sd2147483648;
				pose_pos[i] = acc;
			end
			v[0] = (a[0]*q[0])/2 - (a[1]*q[1])/2 - (a[2]*q[2])/2 - (a[3]*q[3])/2;
			v[1] = (a[0]*q[1])/2 + (a[1]*q[0])/2 + (a[2]*q[3])/2 - (a[3]*q[2])/2;
			v[2] = (a[0]*q[2])/2 - (a[1]*q[3])/2 + (a[2]*q[0])/2 + (a[3]*q[1])/2;
			v[3] = (a[0]*q[3])/2 + (a[1]*q[2])/2 - (a[2]*q[1])/2 + (a[3]*q[0])/2;
			store_normalized(v);
		end
		rebuild_rotation();
		r.pose_quat_w = pose_quat[0][31:0];
		r.pose_quat_x = pose_quat[1][31:0];
		r.pose_quat_y = pose_quat[2][31:0];
		r.pose_quat_z = pose_quat[3][31:0];
		r.pose_trans_x = pose_pos[0][31:0];
		r.pose_trans_y = pose_pos[1][31:0];
		r.pose_trans_z = pose_pos[2][31:0];
		return r;
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input cmd_t c);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expected_poses.push_back(compose_pose(c));
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Drop valid and wait until every expected item has come back
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_poses.size() != 0) @(posedge clk);
	endtask

	function automatic cmd_t make_item(input logic act, input int q[4], input int t[3]);
		cmd_t c;
		c.action = act;
		c.in_quat_w = q[0];
		c.in_quat_x = q[1];
		c.in_quat_y = q[2];
		c.in_quat_z = q[3];
		c.in_trans_x = t[0];
		c.in_trans_y = t[1];
		c.in_trans_z = t[2];
		return c;
	endfunction

	function automatic int rand_quat_part(input int mode);
		case (mode)
			0: return int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
			1: return $signed($urandom) >>> $urandom_range(31, 2);
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t random_item();
		int q[4];
		int t[3];
		int mode;
		mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(1) ? 1 : 2);
		for (int i = 0; i < 4; i++) q[i] = rand_quat_part(mode);
		for (int i = 0; i < 3; i++)
			t[i] = $urandom_range(9) < 8 ? $signed($urandom) >>> $urandom_range(20, 8) : $urandom;
		return make_item($urandom_range(9) < 3, q, t);
	endfunction

	task automatic test_directed();
		int one;
		one = 1 << 30;
		// identity compose from reset, then plain loads and a compose
		send_item(make_item(1'b0, '{one, 0, 0, 0}, '{65536, -65536, 3}));
		send_item(make_item(1'b1, '{one, 0, 0, 0}, '{0, 0, 0}));
		send_item(make_item(1'b1, '{0, one, 0, 0}, '{1, 2, 3}));
		send_item(make_item(1'b0, '{0, 0, one, 0}, '{65536, 65536, 65536}));
		// zero quaternion: load, compose onto it, load out of it, then compose a zero increment
		send_item(make_item(1'b1, '{0, 0, 0, 0}, '{100, 200, 300}));
		send_item(make_item(1'b0, '{one, 0, 0, 0}, '{65536, 1, -1}));
		send_item(make_item(1'b1, '{one, one, one, one}, '{0, 0, 0}));
		send_item(make_item(1'b0, '{0, 0, 0, 0}, '{5, 5, 5}));
		// field extremes and oversized or tiny quaternions
		send_item(make_item(1'b1, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000}, '{32'sh8000_0000, 32'sh7FFF_FFFF, 0}));
		send_item(make_item(1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1},
			'{32'sh7FFF_FFFF, 32'sh8000_0000, -1}));
		send_item(make_item(1'b1, '{1, 0, 0, 0}, '{0, 0, 0}));
		send_item(make_item(1'b1, '{0, 0, 0, -1}, '{0, 0, 0}));
		send_item(make_item(1'b0, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF}, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}));
		// translation saturation both ways
		send_item(make_item(1'b1, '{one, 0, 0, 0}, '{32'sh7FFF_0000, 32'sh8000_1000, 0}));
		send_item(make_item(1'b0, '{one, 0, 0, 0}, '{32'sh7FFF_FFFF, 32'sh8000_0000, 7}));
		send_item(make_item(1'b0, '{one, 0, 0, 0}, '{32'sh7FFF_FFFF, 32'sh8000_0000, 7}));
		send_item(make_item(1'b0, '{0, 0, 0, one}, '{32'sh8000_0000, 32'sh7FFF_FFFF, 7}));
		drain();
	endtask

	task automatic test_random(input int count, input int s_idle, input int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < count; i++) send_item(random_item());
		drain();
	endtask

	// Hold the result side off long enough that the block stalls its input
	task automatic test_result_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_cycles = 2000;
		for (int i = 0; i < 6; i++) send_item(random_item());
		drain();
	endtask

	// Check each accepted result and drive ready for the next edge
	always @(posedge clk) begin
		res_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_poses.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				e = expected_poses.pop_front();
				if (res_ch.data.pose_quat_w !== e.pose_quat_w) begin
					$error("pose_quat_w exp %0d got %0d", e.pose_quat_w, res_ch.data.pose_quat_w);
					errors++;
				end
				if (res_ch.data.pose_quat_x !== e.pose_quat_x) begin
					$error("pose_quat_x exp %0d got %0d", e.pose_quat_x, res_ch.data.pose_quat_x);
					errors++;
				end
				if (res_ch.data.pose_quat_y !== e.pose_quat_y) begin
					$error("pose_quat_y exp %0d got %0d", e.pose_quat_y, res_ch.data.pose_quat_y);
					errors++;
				end
				if (res_ch.data.pose_quat_z !== e.pose_quat_z) begin
					$error("pose_quat_z exp %0d got %0d", e.pose_quat_z, res_ch.data.pose_quat_z);
					errors++;
				end
				if (res_ch.data.pose_trans_x !== e.pose_trans_x) begin
					$error("pose_trans_x exp %0d got %0d", e.pose_trans_x,
						res_ch.data.pose_trans_x);
					errors++;
				end
				if (res_ch.data.pose_trans_y !== e.pose_trans_y) begin
					$error("pose_trans_y exp %0d got %0d", e.pose_trans_y,
						res_ch.data.pose_trans_y);
					errors++;
				end
				if (res_ch.data.pose_trans_z !== e.pose_trans_z) begin
					$error("pose_trans_z exp %0d got %0d", e.pose_trans_z,
						res_ch.data.pose_trans_z);
					errors++;
				end
			end
		end
		if (recv_hold_cycles > 0) begin
			res_ch.ready <= 1'b0;
			recv_hold_cycles--;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Run out of time
	initial begin
		#6_000_000;
		$display("FAIL pose_composition_accumulator");
		$finish;
	end

	initial begin
		errors = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_cycles = 0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		reset_pose();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250, 26, 82);
		test_result_stall();
		test_random(250, 82, 26);
		test_random(250, 0, 0);
		repeat (400) @(posedge clk);
		if (errors == 0) begin
			$display("PASS pose_composition_accumulator");
		end else begin
			$display("FAIL pose_composition_accumulator");
		end
		$finish;
	end
endmodule
`default_nettype wire
